[rtl/dali_forward_frame_builder_assert.svh]
// Assertion macros used by the frame builder top level.
`ifndef DALI_FORWARD_FRAME_BUILDER_ASSERT_SVH
`define DALI_FORWARD_FRAME_BUILDER_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define DFFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("dffb assertion failed");

// Next-cycle implication, held off during reset.
`define DFFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("dffb assertion failed");

`endif

[rtl/dffb_pkg.sv]
// Types, codes and constants of the DALI forward frame builder.
package dffb_pkg;

  // Request kinds carried on the input tuser
  typedef enum logic [2:0] {
    CMD_ADDR_LEVEL  = 3'd0,
    CMD_GROUP_LEVEL = 3'd1,
    CMD_ADDR_CMD    = 3'd2,
    CMD_GROUP_CMD   = 3'd3,
    CMD_BCAST_CMD   = 3'd4
  } cmd_e;

  // Line symbols on the output
  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_STOP = 2'd2
  } sym_e;

  localparam int unsigned FrameSyms = 18;
  localparam int unsigned WordBits  = 16;
  localparam int unsigned IdxW      = $clog2(FrameSyms);
  localparam int unsigned BitPosW   = $clog2(WordBits);

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One frame job: address and data word, and whether it is sent twice
  typedef struct packed {
    logic [WordBits-1:0] word;
    logic                rep;
  } desc_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

[rtl/dffb_front.sv]
// Front end: classifies a request and forms the frame word.
module dffb_front (
  input  dffb_pkg::cmd_e  cmd_i,
  input  logic [6:0]      target_i,
  input  logic [7:0]      value_i,
  input  logic            repeat_req_i,
  output logic            keep_o,
  output dffb_pkg::desc_t desc_o
);

  logic [7:0] addr;
  logic       rep;

  // Address byte and repeat per kind; out-of-range levels and unused kinds are dropped
  always_comb begin
    keep_o = 1'b1;
    addr   = 8'h00;
    rep    = 1'b0;
    case (cmd_i)
      dffb_pkg::CMD_ADDR_LEVEL: begin
        keep_o = ~target_i[6];
        addr   = {target_i[5:0], 1'b0};
      end
      dffb_pkg::CMD_GROUP_LEVEL: begin
        keep_o = ~(|target_i[6:4]);
        addr   = {1'b1, 2'b00, target_i[3:0], 1'b0};
      end
      dffb_pkg::CMD_ADDR_CMD: begin
        addr = {target_i, 1'b1};
        rep  = repeat_req_i;
      end
      dffb_pkg::CMD_GROUP_CMD: begin
        // top target bit lands on the group marker after truncation
        addr = {1'b1, target_i[5:0], 1'b1};
        rep  = repeat_req_i;
      end
      dffb_pkg::CMD_BCAST_CMD: begin
        addr = 8'hFF;
        rep  = repeat_req_i;
      end
      default: begin
        keep_o = 1'b0;
      end
    endcase
  end

  assign desc_o.word = {addr, value_i};
  assign desc_o.rep  = rep;

endmodule

[rtl/dffb_queue.sv]
// Short job queue between the front end and the serialiser.
module dffb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  dffb_pkg::desc_t  push_desc_i,
  input  logic             pop_i,
  output dffb_pkg::desc_t  pop_desc_o,
  output dffb_pkg::q_stat_t stat_o
);

  dffb_pkg::desc_t                 mem_q [dffb_pkg::QDepth];
  logic [dffb_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [dffb_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [dffb_pkg::QCntW-1:0]      cnt_q, cnt_d;

  function automatic logic [dffb_pkg::QPtrW-1:0] ptr_inc(
    input logic [dffb_pkg::QPtrW-1:0] p
  );
    if (p == dffb_pkg::QPtrW'(dffb_pkg::QDepth - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign stat_o.full  = (cnt_q == dffb_pkg::QCntW'(dffb_pkg::QDepth));
  assign stat_o.valid = (cnt_q != '0);
  assign pop_desc_o   = mem_q[rd_ptr_q];

  // pointer and fill updates
  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

[rtl/dffb_back.sv]
// Back end: serialises frame jobs into one symbol a beat.
module dffb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dffb_pkg::q_stat_t q_stat_i,
  input  dffb_pkg::desc_t   q_desc_i,
  output logic              pop_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output dffb_pkg::sym_e    m_sym_o,
  output logic              m_last_o
);

  logic                        busy_q, busy_d;
  logic                        second_q, second_d;
  logic [dffb_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [dffb_pkg::WordBits-1:0] word_q, word_d;
  logic                        rep_q, rep_d;
  logic                        ovalid_q, ovalid_d;
  dffb_pkg::sym_e              sym_q, sym_d;
  logic                        last_q, last_d;

  logic                        adv;
  logic                        at_stop;
  logic                        done;
  logic [dffb_pkg::BitPosW-1:0] bit_pos;

  assign adv     = busy_q && (!ovalid_q || m_ready_i);
  assign at_stop = (idx_q == dffb_pkg::IdxW'(dffb_pkg::FrameSyms - 1));
  assign done    = at_stop && (!rep_q || second_q);
  // symbols 1..16 carry word bits MSB first
  assign bit_pos = dffb_pkg::BitPosW'(dffb_pkg::IdxW'(dffb_pkg::WordBits) - idx_q);
  // load when idle, or straight after the final stop symbol
  assign pop_o   = q_stat_i.valid && (!busy_q || (adv && done));

  always_comb begin
    busy_d   = busy_q;
    second_d = second_q;
    idx_d    = idx_q;
    word_d   = word_q;
    rep_d    = rep_q;
    ovalid_d = ovalid_q && !m_ready_i;
    sym_d    = sym_q;
    last_d   = last_q;

    // emit the current symbol into the output register
    if (adv) begin
      ovalid_d = 1'b1;
      last_d   = done;
      if (idx_q == '0) begin
        sym_d = dffb_pkg::SYM_ONE;
      end else if (at_stop) begin
        sym_d = dffb_pkg::SYM_STOP;
      end else begin
        sym_d = word_q[bit_pos] ? dffb_pkg::SYM_ONE : dffb_pkg::SYM_ZERO;
      end
      if (!at_stop) begin
        idx_d = idx_q + 1'b1;
      end else if (!done) begin
        idx_d    = '0;
        second_d = 1'b1;
      end else begin
        busy_d = 1'b0;
      end
    end

    // take the next job
    if (pop_o) begin
      busy_d   = 1'b1;
      second_d = 1'b0;
      idx_d    = '0;
      word_d   = q_desc_i.word;
      rep_d    = q_desc_i.rep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      second_q <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      second_q <= second_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    rep_q  <= rep_d;
    sym_q  <= sym_d;
    last_q <= last_d;
  end

  assign m_valid_o = ovalid_q;
  assign m_sym_o   = sym_q;
  assign m_last_o  = last_q;

endmodule

[rtl/dali_forward_frame_builder.sv]
// Top level of the DALI forward frame builder.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tuser=cmd, tdata=target,value,repeat_req
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata=symbol, tlast=last
//
// One symbol leaves per cycle while the receiver is ready; a frame is 18 symbols, and a
// request with repeat sends two frames, 36 symbols.
// When idle, a request passes the queue entry and the job registers, then reaches the output register.
// Requests that yield no frame are taken and vanish.
// The two-entry job queue keeps s_axis ready while a frame is being sent, until both entries are full.
// Reset is asynchronous, active low, and empties queue, serialiser and output.
module dali_forward_frame_builder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [6:0] target, [14:7] value, [15] repeat_req
  input  logic [2:0]  s_axis_tuser,  // [2:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [1:0] symbol, [7:2] zero
  output logic        m_axis_tlast
);

  `include "dali_forward_frame_builder_assert.svh"

  logic              keep;
  logic              push;
  logic              pop;
  dffb_pkg::desc_t   front_desc;
  dffb_pkg::desc_t   q_desc;
  dffb_pkg::q_stat_t q_stat;
  dffb_pkg::sym_e    sym;

  dffb_front u_front (
    .cmd_i        (dffb_pkg::cmd_e'(s_axis_tuser)),
    .target_i     (s_axis_tdata[6:0]),
    .value_i      (s_axis_tdata[14:7]),
    .repeat_req_i (s_axis_tdata[15]),
    .keep_o       (keep),
    .desc_o       (front_desc)
  );

  // every beat is taken while there is room; dropped kinds never enter
  assign s_axis_tready = !q_stat.full;
  assign push          = s_axis_tvalid && s_axis_tready && keep;

  dffb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (front_desc),
    .pop_i       (pop),
    .pop_desc_o  (q_desc),
    .stat_o      (q_stat)
  );

  dffb_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .q_desc_i  (q_desc),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_sym_o   (sym),
    .m_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b000000, sym};

  // checks
  `DFFB_ASSERT_IMPL(a_last_is_stop, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast,
                    m_axis_tdata[1:0] == dffb_pkg::SYM_STOP)
  `DFFB_ASSERT_IMPL(a_pop_needs_entry, clk_i, rst_ni, pop, q_stat.valid)
  `DFFB_ASSERT_NEXT(a_repeat_follows, clk_i, rst_ni,
                    m_axis_tvalid && m_axis_tready && !m_axis_tlast &&
                    m_axis_tdata[1:0] == dffb_pkg::SYM_STOP,
                    m_axis_tvalid && m_axis_tdata[1:0] == dffb_pkg::SYM_ONE)

endmodule

[verif/tb_dali_forward_frame_builder.sv]
// Testbench for the DALI forward frame builder: directed and random requests, symbol-level checks.
module tb_dali_forward_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;

  // One expected line symbol and its end-of-request mark
  typedef struct packed {
    dffb_pkg::sym_e symbol;
    logic           last;
  } line_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [6:0] target, [14:7] value, [15] repeat_req
  logic [2:0]  s_axis_tuser;   // [2:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [1:0] symbol, [7:2] zero
  logic        m_axis_tlast;

  line_beat_t  expected_symbols[$];
  int          mismatch_count = 0;
  bit          calm = 1'b0;    // no idling on either side while set
  int          sink_hold = 0;  // cycles the receiver still holds off

  dali_forward_frame_builder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Expected line symbols for one request: zero, one or two frames of start, word bits MSB first, stop
  function automatic void predict_frames(input logic [2:0] kind, input logic [6:0] tgt,
                                         input logic [7:0] val, input logic rep);
    logic [7:0]  addr;
    logic [15:0] word;
    int          n_frames;
    n_frames = 0;
    addr     = '0;
    case (kind)
      dffb_pkg::CMD_ADDR_LEVEL: begin
        if (tgt <= 7'd63) begin
          addr     = {tgt, 1'b0};
          n_frames = 1;
        end
      end
      dffb_pkg::CMD_GROUP_LEVEL: begin
        if (tgt <= 7'd15) begin
          addr     = 8'h80 | {tgt, 1'b0};
          n_frames = 1;
        end
      end
      dffb_pkg::CMD_ADDR_CMD: begin
        addr     = {tgt, 1'b1};
        n_frames = rep ? 2 : 1;
      end
      dffb_pkg::CMD_GROUP_CMD: begin
        addr     = 8'h80 | {tgt, 1'b1};
        n_frames = rep ? 2 : 1;
      end
      dffb_pkg::CMD_BCAST_CMD: begin
        addr     = 8'hFF;
        n_frames = rep ? 2 : 1;
      end
      default: n_frames = 0;
    endcase
    word = {addr, val};
    for (int f = 0; f < n_frames; f++) begin
      expected_symbols.push_back('{symbol: dffb_pkg::SYM_ONE, last: 1'b0});
      for (int b = 15; b >= 0; b--)
        expected_symbols.push_back('{symbol: word[b] ? dffb_pkg::SYM_ONE : dffb_pkg::SYM_ZERO,
                                     last: 1'b0});
      expected_symbols.push_back('{symbol: dffb_pkg::SYM_STOP, last: (f == n_frames - 1)});
    end
  endfunction

  // Offer one request beat, with random gaps ahead of it
  task automatic send_request(input logic [2:0] kind, input logic [6:0] tgt,
                              input logic [7:0] val, input logic rep);
    @(negedge clk_i);
    if (!calm) begin
      while ($urandom_range(99) < 18) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tuser  = kind;
    s_axis_tdata  = {rep, val, tgt};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_frames(kind, tgt, val, rep);
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold = sink_hold - 1;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // Compare each output beat with the oldest expected symbol
  always @(posedge clk_i) begin
    line_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_symbols.size() == 0) begin
        $error("output beat with no symbol expected: symbol %0d last %0b",
               m_axis_tdata[1:0], m_axis_tlast);
        mismatch_count++;
      end else begin
        want = expected_symbols.pop_front();
        if (m_axis_tdata[1:0] !== want.symbol) begin
          $error("symbol: expected %0d, got %0d", want.symbol, m_axis_tdata[1:0]);
          mismatch_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, m_axis_tlast);
          mismatch_count++;
        end
        if (m_axis_tdata[7:2] !== 6'd0) begin
          $error("pad: expected 0, got %0h", m_axis_tdata[7:2]);
          mismatch_count++;
        end
      end
    end
  end

  // Corners: field extremes, every kind, out-of-range targets, repeat, unused kinds
  task automatic test_directed();
    send_request(dffb_pkg::CMD_ADDR_LEVEL,  7'd0,   8'h00, 1'b0);
    send_request(dffb_pkg::CMD_ADDR_LEVEL,  7'd63,  8'hFF, 1'b1);  // repeat ignored on level
    send_request(dffb_pkg::CMD_ADDR_LEVEL,  7'd64,  8'h55, 1'b0);  // out of range, nothing
    send_request(dffb_pkg::CMD_ADDR_LEVEL,  7'd127, 8'hAA, 1'b1);  // out of range, nothing
    send_request(dffb_pkg::CMD_GROUP_LEVEL, 7'd0,   8'hFE, 1'b0);
    send_request(dffb_pkg::CMD_GROUP_LEVEL, 7'd15,  8'h01, 1'b1);  // repeat ignored on level
    send_request(dffb_pkg::CMD_GROUP_LEVEL, 7'd16,  8'h80, 1'b0);  // out of range, nothing
    send_request(dffb_pkg::CMD_ADDR_CMD,    7'd0,   8'h00, 1'b0);
    send_request(dffb_pkg::CMD_ADDR_CMD,    7'd63,  8'hFF, 1'b1);
    send_request(dffb_pkg::CMD_ADDR_CMD,    7'd127, 8'h5A, 1'b0);  // full target, address 8'hFF
    send_request(dffb_pkg::CMD_GROUP_CMD,   7'd0,   8'h90, 1'b0);
    send_request(dffb_pkg::CMD_GROUP_CMD,   7'd15,  8'h0F, 1'b1);
    send_request(dffb_pkg::CMD_GROUP_CMD,   7'd127, 8'hC3, 1'b1);  // address truncated
    send_request(dffb_pkg::CMD_BCAST_CMD,   7'd0,   8'h00, 1'b0);
    send_request(dffb_pkg::CMD_BCAST_CMD,   7'd127, 8'hA5, 1'b1);  // target ignored
    for (int k = int'(dffb_pkg::CMD_BCAST_CMD) + 1; k < 8; k++)
      send_request(3'(k), 7'($urandom), 8'($urandom), 1'($urandom));
    send_request(dffb_pkg::CMD_ADDR_CMD,    7'd42,  8'h3C, 1'b0);
  endtask

  // Mostly well-formed requests, some out-of-range targets and unused kinds
  task automatic test_random(input int count);
    logic [2:0] kind;
    logic [6:0] tgt;
    int         pick;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 5)
        kind = 3'($urandom_range(7, int'(dffb_pkg::CMD_BCAST_CMD) + 1));
      else
        kind = 3'($urandom_range(int'(dffb_pkg::CMD_BCAST_CMD), 0));
      pick = $urandom_range(99);
      case (kind)
        dffb_pkg::CMD_ADDR_LEVEL:
          tgt = (pick < 85) ? 7'($urandom_range(63)) : 7'($urandom_range(127, 64));
        dffb_pkg::CMD_GROUP_LEVEL:
          tgt = (pick < 85) ? 7'($urandom_range(15)) : 7'($urandom_range(127, 16));
        default:
          tgt = 7'($urandom);
      endcase
      send_request(kind, tgt, 8'($urandom), 1'($urandom));
    end
  endtask

  // A stretch with no idling on either side
  task automatic test_back_to_back(input int count);
    calm = 1'b1;
    test_random(count);
    calm = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    sink_hold = 300;
    test_random(12);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random(200);
    test_back_to_back(40);
    test_backpressure();
    test_random(80);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("** dali_forward_frame_builder: PASSED **");
    end else begin
      $display("** dali_forward_frame_builder: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("** dali_forward_frame_builder: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/dffb_pkg.sv
rtl/dffb_front.sv
rtl/dffb_queue.sv
rtl/dffb_back.sv
rtl/dali_forward_frame_builder.sv
verif/tb_dali_forward_frame_builder.sv
